FILE: rtl/core/lfp_pkg.sv
// Package for the lidar frame parser: byte and distance widths, the frame
// header value and the one-hot parse state type. No dependencies.
package lfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 16;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h59;

  // Each state names the byte position that the next transfer fills.
  typedef enum logic [9:0] {
    S_HUNT = 10'b00_0000_0001,  // looking for the first header byte
    S_HDR1 = 10'b00_0000_0010,  // first header seen, expect second
    S_HDR2 = 10'b00_0000_0100,  // expect distance low
    S_DLO  = 10'b00_0000_1000,  // expect distance high
    S_DHI  = 10'b00_0001_0000,  // expect strength low
    S_SLO  = 10'b00_0010_0000,  // expect strength high
    S_SHI  = 10'b00_0100_0000,  // expect reserved byte
    S_RSV  = 10'b00_1000_0000,  // expect quality byte
    S_QUAL = 10'b01_0000_0000,  // expect checksum
    S_DONE = 10'b10_0000_0000   // good frame just ended
  } parse_state_t;

endpackage

FILE: rtl/core/lfp_byte_if.sv
// Valid/ready channel carrying one received serial byte.
// Depends on lfp_pkg for the byte width.
interface lfp_byte_if import lfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/lfp_dist_if.sv
// Valid/ready channel carrying one decoded distance in centimeters.
// Depends on lfp_pkg for the distance width.
interface lfp_dist_if import lfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, output distance_cm, input ready);
  modport sink   (input valid, input distance_cm, output ready);
endinterface

FILE: rtl/core/lidar_frame_parser.sv
// Lidar frame parser: one byte per transfer in, a distance out for each
// nine-byte frame whose sum checksum matches. Throughput: one byte every
// cycle while the skid entry is empty; the parse state and running sum
// update on each byte transfer, and a two-entry output stage (output
// register plus skid) holds results while the sink stalls. Synchronous
// active-high reset returns to header hunt, clears the sum and empties the
// output stage.
// Depends on lfp_pkg, lfp_byte_if and lfp_dist_if.
module lidar_frame_parser import lfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  lfp_byte_if.sink   rx,
  lfp_dist_if.source distance
);

  parse_state_t      state, state_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] dist_lo, dist_hi;

  logic              out_valid, skid_valid;
  logic [DIST_W-1:0] out_data, skid_data;

  logic              rx_fire, push, pop;
  logic [BYTE_W-1:0] sum_add;
  logic              is_header;

  assign rx.ready    = !skid_valid;
  assign rx_fire     = rx.valid && rx.ready;
  assign pop         = out_valid && distance.ready;
  assign sum_add     = running_sum + rx.rx_byte;
  assign is_header   = (rx.rx_byte == HEADER_BYTE);
  assign push        = rx_fire && (state == S_QUAL) && (rx.rx_byte == running_sum);

  assign distance.valid       = out_valid;
  assign distance.distance_cm = out_data;

  always_comb begin
    state_next       = state;
    running_sum_next = running_sum;
    unique case (state)
      S_HDR1: begin
        if (is_header) begin
          state_next       = S_HDR2;
          running_sum_next = sum_add;
        end else begin
          state_next       = S_HUNT;
          running_sum_next = '0;
        end
      end
      S_HDR2: begin state_next = S_DLO; running_sum_next = sum_add; end
      S_DLO:  begin state_next = S_DHI; running_sum_next = sum_add; end
      S_DHI:  begin state_next = S_SLO; running_sum_next = sum_add; end
      S_SLO:  begin state_next = S_SHI; running_sum_next = sum_add; end
      S_SHI:  begin state_next = S_RSV; running_sum_next = sum_add; end
      S_RSV:  begin state_next = S_QUAL; running_sum_next = sum_add; end
      S_QUAL: begin
        state_next       = (rx.rx_byte == running_sum) ? S_DONE : S_HUNT;
        running_sum_next = '0;
      end
      default: begin
        // hunt and just-after-frame behave alike
        if (is_header) begin
          state_next       = S_HDR1;
          running_sum_next = rx.rx_byte;
        end else begin
          state_next       = S_HUNT;
          running_sum_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_HUNT;
      running_sum <= '0;
    end else if (rx_fire) begin
      state       <= state_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && state == S_HDR2) dist_lo <= rx.rx_byte;
    if (rx_fire && state == S_DLO)  dist_hi <= rx.rx_byte;
  end

  // Output register backed by a skid entry so a byte can transfer while a
  // finished distance is still waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= {dist_hi, dist_lo};
      end else begin
        out_data  <= {dist_hi, dist_lo};
      end
    end else if (push) begin
      skid_data <= {dist_hi, dist_lo};
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("parse state not one-hot");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_hunt_sum_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_HUNT |-> running_sum == '0)
    else $error("running sum not cleared while hunting");

  a_result_after_check: assert property (@(posedge clk) disable iff (rst)
    push |=> state == S_DONE && out_valid)
    else $error("checksum match did not end frame with a result");

endmodule

FILE: tb/lidar_frame_parser_tb.sv
// Self-checking bench for lidar_frame_parser: a directed table of bytes, then random
// frames, bad checksums, broken headers and noise, checked against a per-byte parser model.
// Depends on lfp_pkg, lfp_byte_if, lfp_dist_if and the lidar_frame_parser RTL.
module lidar_frame_parser_tb;
  import lfp_pkg::*;

  localparam int N_DIRECTED  = 29;
  localparam int N_RANDOM    = 1000;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              known;        // distance_cm below is the result of this byte
    logic [DIST_W-1:0] distance_cm;
  } byte_row_t;

  // Bad second header, a zero frame, an all-ones frame right behind it, then a frame
  // whose checksum is off by one.
  byte_row_t directed_rows [N_DIRECTED] = '{
    '{HEADER_BYTE, 1'b0, 16'h0000}, '{8'hA6, 1'b0, 16'h0000},
    '{HEADER_BYTE, 1'b0, 16'h0000}, '{HEADER_BYTE, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000},
    '{8'hB2, 1'b1, 16'h0000},
    '{HEADER_BYTE, 1'b0, 16'h0000}, '{HEADER_BYTE, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 16'h0000}, '{8'hFF, 1'b0, 16'h0000}, '{8'hFF, 1'b0, 16'h0000},
    '{8'hFF, 1'b0, 16'h0000}, '{8'hFF, 1'b0, 16'h0000}, '{8'hFF, 1'b0, 16'h0000},
    '{8'hAC, 1'b1, 16'hFFFF},
    '{HEADER_BYTE, 1'b0, 16'h0000}, '{HEADER_BYTE, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 16'h0000}, '{8'h12, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000},
    '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000}, '{8'h00, 1'b0, 16'h0000},
    '{8'hF9, 1'b0, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfp_byte_if rx_if ();
  lfp_dist_if dist_if ();

  lidar_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_if),
    .distance (dist_if)
  );

  always #6 clk = ~clk;

  byte_row_t         byte_stream [$];
  byte_row_t         cur_row = '0;
  logic [DIST_W-1:0] distance_expected [$];
  int                sent_idx = 0;
  bit                idle_on = 1'b0;
  bit                quiet = 1'b0;
  bit                long_hold_done = 1'b0;
  int                error_count = 0;
  int                cycle_count = 0;

  // Parser model state
  parse_state_t      frame_state = S_HUNT;
  logic [BYTE_W-1:0] frame_sum = '0;
  logic [DIST_W-1:0] frame_dist = '0;

  task automatic parse_byte(input logic [BYTE_W-1:0] b, output bit got,
                            output logic [DIST_W-1:0] dist_val);
    got      = 1'b0;
    dist_val = '0;
    case (frame_state)
      S_HDR1: begin
        if (b == HEADER_BYTE) begin
          frame_sum   += b;
          frame_state = S_HDR2;
        end else begin
          frame_sum   = '0;
          frame_state = S_HUNT;
        end
      end
      S_HDR2: begin
        frame_dist[7:0] = b;
        frame_sum       += b;
        frame_state     = S_DLO;
      end
      S_DLO: begin
        frame_dist[15:8] = b;
        frame_sum        += b;
        frame_state      = S_DHI;
      end
      S_DHI, S_SLO, S_SHI, S_RSV: begin
        frame_sum   += b;
        // one-hot: a left shift steps to the next byte position
        frame_state = parse_state_t'(frame_state << 1);
      end
      S_QUAL: begin
        if (b == frame_sum) begin
          got         = 1'b1;
          dist_val    = frame_dist;
          frame_state = S_DONE;
        end else begin
          frame_state = S_HUNT;
        end
        frame_sum = '0;
      end
      default: begin
        if (b == HEADER_BYTE) begin
          frame_sum   = b;
          frame_state = S_HDR1;
        end else begin
          frame_sum   = '0;
          frame_state = S_HUNT;
        end
      end
    endcase
  endtask

  // Field bytes lean toward the extremes.
  function automatic logic [BYTE_W-1:0] field_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lidar_frame_parser_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin : check_and_predict
    bit                got;
    logic [DIST_W-1:0] exp_dist;
    if (!rst) begin
      if (dist_if.valid && dist_if.ready) begin
        if (distance_expected.size() == 0) begin
          $display("%0t: distance_cm expected none, got %h", $time, dist_if.distance_cm);
          error_count++;
        end else begin
          exp_dist = distance_expected.pop_front();
          if (dist_if.distance_cm !== exp_dist) begin
            $display("%0t: distance_cm expected %h, got %h", $time, exp_dist,
                     dist_if.distance_cm);
            error_count++;
          end
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        parse_byte(rx_if.rx_byte, got, exp_dist);
        if (cur_row.known) begin
          got      = 1'b1;
          exp_dist = cur_row.distance_cm;
        end
        if (got) distance_expected.push_back(exp_dist);
      end
    end
  end

  initial begin : drive_bytes
    logic [BYTE_W-1:0] fb [9];
    logic [BYTE_W-1:0] sum;
    int                pick;
    int                len;
    byte_row_t         row;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;

    foreach (directed_rows[k]) byte_stream.push_back(directed_rows[k]);
    while (byte_stream.size() < N_DIRECTED + N_RANDOM) begin
      pick  = $urandom_range(0, 99);
      fb[0] = HEADER_BYTE;
      fb[1] = HEADER_BYTE;
      sum   = HEADER_BYTE + HEADER_BYTE;
      for (int j = 2; j < 8; j++) begin
        fb[j] = field_byte();
        sum   += fb[j];
      end
      fb[8] = sum;
      len   = 9;
      if (pick >= 94) begin
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++)
          fb[j] = ($urandom_range(0, 3) == 0) ? HEADER_BYTE : field_byte();
      end else if (pick >= 88) begin
        len = $urandom_range(3, 8);         // frame cut short
      end else if (pick >= 80) begin
        fb[1] = field_byte();
        if (fb[1] == HEADER_BYTE) fb[1] = 8'hA6;
        len = 2;
      end else if (pick >= 70) begin
        fb[8] = sum + 8'($urandom_range(1, 255));
      end
      for (int j = 0; j < len; j++) begin
        row         = '0;
        row.rx_byte = fb[j];
        byte_stream.push_back(row);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < byte_stream.size(); i++) begin
      sent_idx = i;
      quiet    = (i >= byte_stream.size() - QUIET_TAIL);
      idle_on  = !quiet && ((i / 100) % 3 != 2);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_if.valid = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      cur_row       = byte_stream[i];
      rx_if.valid   = 1'b1;
      rx_if.rx_byte = cur_row.rx_byte;
      do @(posedge clk); while (!rx_if.ready);
      @(negedge clk);
    end
    rx_if.valid = 1'b0;
    cur_row     = '0;

    while (distance_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("lidar_frame_parser_tb: clean");
    else $display("lidar_frame_parser_tb: errors");
    $finish;
  end

  initial begin : drain_distances
    dist_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && sent_idx >= HOLD_AT) begin
        // long hold-off: output stage fills and the byte input must stall
        dist_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        dist_if.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      dist_if.ready = 1'b1;
      @(negedge clk);
    end
  end

endmodule
